/* rtl/fctp_pkg.sv */
// ----------------------------------------------------------------------------
// Function call time profiler package
// Transaction types, result codes and sequencer states shared by the profiler.
// ----------------------------------------------------------------------------
package fctp_pkg;

  // Fixed field widths of the event and result transactions.
  localparam int FUNC_ID_BITS = 8;
  localparam int STAMP_BITS   = 48;
  localparam int TALLY_BITS   = 32;
  localparam int ERR_BITS     = 2;

  // Default sizing of the profiler table.
  localparam int NUM_FUNCTIONS_DEF = 256;
  localparam int TIME_BITS_DEF     = 48;
  localparam int DEPTH_BITS_DEF    = 16;

  // Event kinds.
  localparam logic MODE_ENTER = 1'b0;
  localparam logic MODE_EXIT  = 1'b1;

  // Result codes reported with every event.
  typedef enum logic [ERR_BITS-1:0] {
    ERR_OK        = 2'd0,
    ERR_NO_ENTRY  = 2'd1,
    ERR_DEPTH_OVF = 2'd2
  } err_t;

  // Operations of the shared time unit.
  typedef enum logic {
    ALU_SUB_CLAMP = 1'b0,
    ALU_ADD_SAT   = 1'b1
  } alu_op_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_LOAD_F,
    ST_DECIDE,
    ST_LOAD_C,
    ST_C_DIFF,
    ST_C_ADD,
    ST_C_WRITE,
    ST_SET_F,
    ST_X_DIFF,
    ST_X_TOTAL,
    ST_X_GAP,
    ST_X_RUN,
    ST_X_SELF,
    ST_WRITE_F
  } state_t;

  // One enter or exit event.
  typedef struct packed {
    logic                    mode;
    logic [FUNC_ID_BITS-1:0] function_id;
    logic [STAMP_BITS-1:0]   timestamp;
  } event_t;

  // Counters of one function after an event.
  typedef struct packed {
    logic [FUNC_ID_BITS-1:0] result_function;
    logic [TALLY_BITS-1:0]   calls_made;
    logic [STAMP_BITS-1:0]   time_self;
    logic [STAMP_BITS-1:0]   time_total;
    logic [ERR_BITS-1:0]     error_code;
  } result_t;

endpackage

/* rtl/function_call_time_profiler.sv */
// ----------------------------------------------------------------------------
// Function call time profiler
// Per-function entry, run, total and self time bookkeeping over a table memory.
// ----------------------------------------------------------------------------
// An event transaction is taken when start is high and busy is low. The block
// then stays busy and strobes done for one cycle with the result in its last
// busy cycle, so a new event can be taken only after the previous done. The
// busy time is set by the single-port table memory, which is read and written
// once per touched function, and by the one shared subtract/add unit, which
// performs up to five time operations in sequence on a final exit. Plain
// entries and errors are the shortest; a first entry with no caller adds a
// step. A final exit is longer, and longer still when no first entry has come
// since the previous final exit; a first entry with a live caller is as long
// as that longest exit. The receiver cannot stall: the result is valid only
// while done is high. After reset a clearing pass zeroes every table entry,
// during which busy stays high.
module function_call_time_profiler #(
  parameter int NUM_FUNCTIONS = fctp_pkg::NUM_FUNCTIONS_DEF,
  parameter int TIME_BITS     = fctp_pkg::TIME_BITS_DEF,
  parameter int DEPTH_BITS    = fctp_pkg::DEPTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  fctp_pkg::event_t  evt,
  output logic              busy,
  output logic              done,
  output fctp_pkg::result_t result
);

  localparam int IDX_W = (NUM_FUNCTIONS > 1) ? $clog2(NUM_FUNCTIONS) : 1;
  localparam int ID_W  = fctp_pkg::FUNC_ID_BITS;
  localparam logic [ID_W:0] MOD_N =
    (ID_W + 1)'((NUM_FUNCTIONS < 2 ** ID_W) ? NUM_FUNCTIONS : 2 ** ID_W);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FUNCTIONS - 1);

  // One table entry per function.
  typedef struct packed {
    logic [TIME_BITS-1:0]            entry;
    logic [TIME_BITS-1:0]            run;
    logic [DEPTH_BITS-1:0]           depth;
    logic                            caller_valid;
    logic [IDX_W-1:0]                caller;
    logic [fctp_pkg::TALLY_BITS-1:0] tally;
    logic [TIME_BITS-1:0]            self_sum;
    logic [TIME_BITS-1:0]            total_sum;
  } rec_t;

  // Control registers.
  fctp_pkg::state_t state, state_next;
  logic [IDX_W-1:0] clr_addr;
  logic             current_valid;
  logic [IDX_W-1:0] current_function;
  logic             last_exit_valid;
  logic [TIME_BITS-1:0] last_exit_stamp;

  // Payload registers.
  logic                 mode_q;
  logic [IDX_W-1:0]     fidx;
  logic [TIME_BITS-1:0] now_q;
  rec_t                 rec;
  rec_t                 crec;
  logic [TIME_BITS-1:0] acc;
  fctp_pkg::err_t       err;

  // Entry and result code after the depth and tally update.
  rec_t                 rec_upd;
  fctp_pkg::err_t       err_upd;

  // Table memory.
  rec_t             mem [NUM_FUNCTIONS];
  rec_t             rd_q;
  logic             mem_re;
  logic             mem_we;
  logic [IDX_W-1:0] mem_raddr;
  logic [IDX_W-1:0] mem_waddr;
  rec_t             mem_wdata;

  // Shared time unit.
  fctp_pkg::alu_op_t    alu_op;
  logic [TIME_BITS-1:0] alu_a;
  logic [TIME_BITS-1:0] alu_b;
  logic [TIME_BITS:0]   alu_sum;
  logic [TIME_BITS-1:0] alu_y;
  logic                 alu_sub;

  // Function index reduced into the table, one compare-subtract per id bit.
  logic [ID_W:0]    fold;
  logic [IDX_W-1:0] f_in;

  always_comb begin
    fold = '0;
    for (int i = ID_W - 1; i >= 0; i--) begin
      fold = {fold[ID_W-1:0], evt.function_id[i]};
      if (fold >= MOD_N) begin
        fold = fold - MOD_N;
      end
    end
  end

  assign f_in = IDX_W'(fold);

  // The shared unit: clamped subtract or saturating add on one adder.
  assign alu_sub = (alu_op == fctp_pkg::ALU_SUB_CLAMP);
  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                 + {{TIME_BITS{1'b0}}, alu_sub};

  always_comb begin
    if (alu_sub) begin
      alu_y = alu_sum[TIME_BITS] ? alu_sum[TIME_BITS-1:0] : '0;
    end else begin
      alu_y = alu_sum[TIME_BITS] ? '1 : alu_sum[TIME_BITS-1:0];
    end
  end

  // Memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  // Depth, call count and result code of the entry just read.
  always_comb begin
    rec_upd = rd_q;
    err_upd = fctp_pkg::ERR_OK;
    if (mode_q == fctp_pkg::MODE_ENTER) begin
      if (rd_q.depth == '1) begin
        err_upd = fctp_pkg::ERR_DEPTH_OVF;
      end else begin
        rec_upd.depth = rd_q.depth + DEPTH_BITS'(1);
      end
    end else if (rd_q.depth == '0) begin
      err_upd = fctp_pkg::ERR_NO_ENTRY;
    end else begin
      rec_upd.depth = rd_q.depth - DEPTH_BITS'(1);
      if (rd_q.tally != '1) begin
        rec_upd.tally = rd_q.tally + fctp_pkg::TALLY_BITS'(1);
      end
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      fctp_pkg::ST_IDLE: begin
        if (start) begin
          state_next = fctp_pkg::ST_LOAD_F;
        end
      end
      fctp_pkg::ST_CLEAR: begin
        if (clr_addr == LAST_IDX) begin
          state_next = fctp_pkg::ST_IDLE;
        end
      end
      fctp_pkg::ST_LOAD_F: begin
        state_next = fctp_pkg::ST_DECIDE;
      end
      fctp_pkg::ST_DECIDE: begin
        state_next = fctp_pkg::ST_WRITE_F;
        if (mode_q == fctp_pkg::MODE_ENTER) begin
          if (rd_q.depth == '0) begin
            state_next = current_valid ? fctp_pkg::ST_LOAD_C : fctp_pkg::ST_SET_F;
          end
        end else if (rd_q.depth == DEPTH_BITS'(1)) begin
          state_next = fctp_pkg::ST_X_DIFF;
        end
      end
      fctp_pkg::ST_LOAD_C:  state_next = fctp_pkg::ST_C_DIFF;
      fctp_pkg::ST_C_DIFF:  state_next = fctp_pkg::ST_C_ADD;
      fctp_pkg::ST_C_ADD:   state_next = fctp_pkg::ST_C_WRITE;
      fctp_pkg::ST_C_WRITE: state_next = fctp_pkg::ST_SET_F;
      fctp_pkg::ST_SET_F:   state_next = fctp_pkg::ST_WRITE_F;
      fctp_pkg::ST_X_DIFF:  state_next = fctp_pkg::ST_X_TOTAL;
      fctp_pkg::ST_X_TOTAL: begin
        state_next = last_exit_valid ? fctp_pkg::ST_X_GAP : fctp_pkg::ST_X_SELF;
      end
      fctp_pkg::ST_X_GAP:   state_next = fctp_pkg::ST_X_RUN;
      fctp_pkg::ST_X_RUN:   state_next = fctp_pkg::ST_X_SELF;
      fctp_pkg::ST_X_SELF:  state_next = fctp_pkg::ST_WRITE_F;
      fctp_pkg::ST_WRITE_F: state_next = fctp_pkg::ST_IDLE;
      default:              state_next = fctp_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake, memory ports and unit operands.
  always_comb begin
    busy      = (state != fctp_pkg::ST_IDLE);
    done      = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_raddr = fidx;
    mem_waddr = fidx;
    mem_wdata = rec;
    alu_op    = fctp_pkg::ALU_ADD_SAT;
    alu_a     = acc;
    alu_b     = acc;
    case (state)
      fctp_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      fctp_pkg::ST_LOAD_F: begin
        mem_re = 1'b1;
      end
      fctp_pkg::ST_LOAD_C: begin
        mem_re    = 1'b1;
        mem_raddr = current_function;
      end
      fctp_pkg::ST_C_DIFF: begin
        alu_op = fctp_pkg::ALU_SUB_CLAMP;
        alu_a  = now_q;
        alu_b  = last_exit_valid ? last_exit_stamp : rd_q.entry;
      end
      fctp_pkg::ST_C_ADD: begin
        alu_a = crec.run;
      end
      fctp_pkg::ST_C_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = current_function;
        mem_wdata = crec;
      end
      fctp_pkg::ST_X_DIFF: begin
        alu_op = fctp_pkg::ALU_SUB_CLAMP;
        alu_a  = now_q;
        alu_b  = rec.entry;
      end
      fctp_pkg::ST_X_TOTAL: begin
        alu_a = rec.total_sum;
      end
      fctp_pkg::ST_X_GAP: begin
        alu_op = fctp_pkg::ALU_SUB_CLAMP;
        alu_a  = now_q;
        alu_b  = last_exit_stamp;
      end
      fctp_pkg::ST_X_RUN: begin
        alu_a = rec.run;
      end
      fctp_pkg::ST_X_SELF: begin
        alu_a = rec.self_sum;
      end
      fctp_pkg::ST_WRITE_F: begin
        mem_we = 1'b1;
        done   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // The result always shows the working entry; done marks when it is final.
  always_comb begin
    result.result_function = ID_W'(fidx);
    result.calls_made      = rec.tally;
    result.time_self       = fctp_pkg::STAMP_BITS'(rec.self_sum);
    result.time_total      = fctp_pkg::STAMP_BITS'(rec.total_sum);
    result.error_code      = err;
  end

  // Control state: sequencer, clearing counter and the current call context.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= fctp_pkg::ST_CLEAR;
      clr_addr         <= '0;
      current_valid    <= 1'b0;
      current_function <= '0;
      last_exit_valid  <= 1'b0;
      last_exit_stamp  <= '0;
    end else begin
      state <= state_next;
      if (state == fctp_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
      if (state == fctp_pkg::ST_SET_F) begin
        current_function <= fidx;
        current_valid    <= 1'b1;
        last_exit_valid  <= 1'b0;
        last_exit_stamp  <= '0;
      end
      if (state == fctp_pkg::ST_X_SELF) begin
        current_function <= rec.caller;
        current_valid    <= rec.caller_valid;
        last_exit_valid  <= 1'b1;
        last_exit_stamp  <= now_q;
      end
    end
  end

  // Working registers of the event in flight.
  always_ff @(posedge clk) begin
    case (state)
      fctp_pkg::ST_IDLE: begin
        if (start) begin
          mode_q <= evt.mode;
          fidx   <= f_in;
          now_q  <= TIME_BITS'(evt.timestamp);
        end
      end
      fctp_pkg::ST_DECIDE: begin
        rec <= rec_upd;
        err <= err_upd;
      end
      fctp_pkg::ST_C_DIFF: begin
        crec <= rd_q;
        acc  <= alu_y;
      end
      fctp_pkg::ST_C_ADD: begin
        crec.run <= alu_y;
      end
      fctp_pkg::ST_SET_F: begin
        rec.run          <= '0;
        rec.entry        <= now_q;
        rec.caller_valid <= current_valid;
        rec.caller       <= current_function;
      end
      fctp_pkg::ST_X_DIFF: begin
        acc <= alu_y;
      end
      fctp_pkg::ST_X_TOTAL: begin
        rec.total_sum <= alu_y;
      end
      fctp_pkg::ST_X_GAP: begin
        acc <= alu_y;
      end
      fctp_pkg::ST_X_RUN: begin
        rec.run <= alu_y;
        acc     <= alu_y;
      end
      fctp_pkg::ST_X_SELF: begin
        rec.self_sum     <= alu_y;
        rec.caller_valid <= 1'b0;
        rec.caller       <= '0;
        rec.entry        <= '0;
      end
      default: begin
      end
    endcase
  end

  // A result strobe lasts a single cycle.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // The block is ready again right after a result.
  a_ready_after_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy still high after the result");

  // An accepted transaction makes the block busy.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("event accepted but block not busy");

  // A first entry makes the entered function current.
  a_enter_current: assert property (@(posedge clk) disable iff (rst)
    (state == fctp_pkg::ST_SET_F) |=> (current_valid && current_function == fidx))
    else $error("entered function did not become current");

  // A depth overflow can only come from an entry event.
  a_ovf_on_entry: assert property (@(posedge clk) disable iff (rst)
    (done && err == fctp_pkg::ERR_DEPTH_OVF) |-> (mode_q == fctp_pkg::MODE_ENTER))
    else $error("depth overflow reported for an exit event");

endmodule
